// File: src/fhpa_pkg.sv
// Package: shared types and constants for the FIFO handle pool allocator.
`default_nettype none
package fhpa_pkg;

    localparam int POOL_SIZE   = 256;
    // Handles travel in 8 bits, so the usable pool is capped at 256.
    localparam int CAP         = (POOL_SIZE < 256) ? POOL_SIZE : 256;
    localparam int HANDLE_W    = 8;
    localparam int QUEUE_DEPTH = 256;
    localparam int COUNT_W     = 9;

    typedef logic [HANDLE_W-1:0] handle_t;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_TRY   = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK            = 2'd0,
        STAT_NONE_FREED    = 2'd1,
        STAT_NOT_ALLOCATED = 2'd2,
        STAT_EXHAUSTED     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage
`default_nettype wire

// File: src/fhpa_if.sv
// Interfaces: request and response channels of the handle pool allocator.
`default_nettype none
interface fhpa_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [fhpa_pkg::HANDLE_W-1:0] handle_in;

    modport source (output valid, output command, output handle_in, input ready);
    modport sink   (input valid, input command, input handle_in, output ready);
endinterface

interface fhpa_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [fhpa_pkg::HANDLE_W-1:0] handle_out;
    logic [1:0]                status;

    modport source (output valid, output handle_out, output status, input ready);
    modport sink   (input valid, input handle_out, input status, output ready);
endinterface
`default_nettype wire

// File: src/fhpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fhpa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: src/fifo_handle_pool_allocator.sv
// Top level: handle pool allocator with a FIFO free list and an in-use bitmap.
//
// Hands out 8-bit handles 0..CAP-1. Each request word yields exactly one
// response word. Allocate pops the oldest freed handle, else issues the next
// never-used handle, else answers "exhausted"; try-allocate only pops freed
// handles; deallocate checks the in-use bitmap and queues the handle if it
// was allocated. Accepting a word launches reads of the free-list RAM (at
// the head) and the bitmap RAM (at handle_in), whose registered data is
// used in the execute state, where all writes happen. No new word is
// accepted until the execute state has finished the last one. The response
// sits in an output register; a new request is taken while an older response
// waits, and the execute state stalls only if that register is still full.
// The bitmap RAM has per-entry valid flops cleared by reset, so no clearing
// pass is needed after reset. Command code 3 is a no-op that answers ok.
`default_nettype none
module fifo_handle_pool_allocator (
    input wire logic   clk,
    input wire logic   rst_n,
    fhpa_req_if.sink   req,
    fhpa_rsp_if.source rsp
);
    import fhpa_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_V   = COUNT_W'(CAP);
    localparam logic [COUNT_W-1:0] DEPTH_V = COUNT_W'(QUEUE_DEPTH);

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    handle_t                hin_reg, hin_next;
    logic [COUNT_W-1:0]     fresh_reg, fresh_next;
    handle_t                head_reg, head_next;
    handle_t                tail_reg, tail_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] mapvalid_reg, mapvalid_next;
    logic                   rspvalid_reg, rspvalid_next;
    handle_t                hout_reg, hout_next;
    status_t                stat_reg, stat_next;

    // RAM ports
    logic    rd_en;
    logic    q_we;
    handle_t q_rdata;
    logic    m_we;
    handle_t m_waddr;
    logic    m_wdata;
    logic    m_rdata;

    logic    accept;
    logic    exec_go;
    logic    in_use;

    assign accept  = (state_reg == ST_IDLE) && req.valid;
    assign exec_go = (state_reg == ST_EXEC) && (!rspvalid_reg || rsp.ready);
    assign rd_en   = accept;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rspvalid_reg;
    assign rsp.handle_out = hout_reg;
    assign rsp.status     = stat_reg;

    // free list: read at head on accept, written at tail on release
    fhpa_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(HANDLE_W)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (hin_reg),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // in-use bitmap: read at handle_in on accept
    fhpa_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(1)) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (rd_en),
        .raddr (req.handle_in),
        .rdata (m_rdata)
    );

    // an entry never written since reset reads as not in use
    assign in_use = ({1'b0, hin_reg} < CAP_V) && mapvalid_reg[hin_reg] && m_rdata;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        hin_next      = hin_reg;
        fresh_next    = fresh_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        mapvalid_next = mapvalid_reg;
        rspvalid_next = rspvalid_reg;
        hout_next     = hout_reg;
        stat_next     = stat_reg;
        q_we          = 1'b0;
        m_we          = 1'b0;
        m_waddr       = hin_reg;
        m_wdata       = 1'b0;

        if (rspvalid_reg && rsp.ready)
        begin
            rspvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_t'(req.command);
                    hin_next   = req.handle_in;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    hout_next     = '0;
                    stat_next     = STAT_OK;
                    rspvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    case (cmd_reg)
                        CMD_ALLOC, CMD_TRY:
                        begin
                            if (count_reg != '0)
                            begin
                                // reuse oldest freed handle
                                hout_next  = q_rdata;
                                head_next  = head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                m_we       = 1'b1;
                                m_waddr    = q_rdata;
                                m_wdata    = 1'b1;
                                mapvalid_next[q_rdata] = 1'b1;
                            end
                            else if (cmd_reg == CMD_TRY)
                            begin
                                stat_next = STAT_NONE_FREED;
                            end
                            else if (fresh_reg < CAP_V)
                            begin
                                hout_next  = fresh_reg[HANDLE_W-1:0];
                                fresh_next = fresh_reg + 1'b1;
                                m_we       = 1'b1;
                                m_waddr    = fresh_reg[HANDLE_W-1:0];
                                m_wdata    = 1'b1;
                                mapvalid_next[fresh_reg[HANDLE_W-1:0]] = 1'b1;
                            end
                            else
                            begin
                                stat_next = STAT_EXHAUSTED;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (in_use)
                            begin
                                m_we    = 1'b1;
                                m_waddr = hin_reg;
                                m_wdata = 1'b0;
                                mapvalid_next[hin_reg] = 1'b1;
                                // full queue cannot happen; guarded anyway
                                if (count_reg < DEPTH_V)
                                begin
                                    q_we       = 1'b1;
                                    tail_next  = tail_reg + 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                stat_next = STAT_NOT_ALLOCATED;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fresh_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            mapvalid_reg <= '0;
            rspvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fresh_reg    <= fresh_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            mapvalid_reg <= mapvalid_next;
            rspvalid_reg <= rspvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        hin_reg  <= hin_next;
        hout_reg <= hout_next;
        stat_reg <= stat_next;
    end
endmodule
`default_nettype wire

// File: bench/tb.sv
// Testbench: drives request words into the handle pool allocator and checks every reply.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhpa_pkg::*;

    // Cycles with no word moving on either channel before the run is declared hung.
    // The longest legal quiet stretch is the long reply hold plus a send gap.
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;   // reply-side hold-off that backs up the block
    localparam int HOLD_AFTER  = 100;  // replies seen before the long hold starts
    localparam int SETTLE      = 20;   // quiet cycles after the last reply
    localparam int CALM_FROM   = 520;  // random words from here on: no idling at all
    localparam int MAX_SHOWN   = 10;

    // Random traffic shapes: fill the pool to exhaustion, drain it back into the
    // freed list, then a balanced mix.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;
    localparam int MIX_LEN [3] = '{280, 200, 140};

    typedef struct {
        handle_t handle;
        status_t status;
    } reply_t;

    // Directed word: typed-in reply where it is obvious, else predicted.
    typedef struct packed {
        cmd_t    command;
        handle_t handle;
        logic    typed;
        handle_t want_handle;
        status_t want_status;
    } stim_row_t;

    localparam int N_DIRECTED = 22;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{CMD_TRY,   8'd0,   1'b1, 8'd0, STAT_NONE_FREED},    // nothing freed yet
        '{CMD_FREE,  8'd0,   1'b1, 8'd0, STAT_NOT_ALLOCATED}, // never issued
        '{CMD_FREE,  8'd255, 1'b1, 8'd0, STAT_NOT_ALLOCATED},
        '{CMD_NOP,   8'd255, 1'b1, 8'd0, STAT_OK},            // unused code answers ok
        '{CMD_ALLOC, 8'd0,   1'b1, 8'd0, STAT_OK},            // fresh handles in order
        '{CMD_ALLOC, 8'd0,   1'b1, 8'd1, STAT_OK},
        '{CMD_ALLOC, 8'd255, 1'b1, 8'd2, STAT_OK},
        '{CMD_FREE,  8'd1,   1'b1, 8'd0, STAT_OK},
        '{CMD_FREE,  8'd1,   1'b1, 8'd0, STAT_NOT_ALLOCATED}, // double release
        '{CMD_TRY,   8'd0,   1'b1, 8'd1, STAT_OK},            // reuse from freed list
        '{CMD_FREE,  8'd0,   1'b0, 8'd0, STAT_OK},
        '{CMD_FREE,  8'd2,   1'b0, 8'd0, STAT_OK},
        '{CMD_ALLOC, 8'd0,   1'b1, 8'd0, STAT_OK},            // oldest freed first
        '{CMD_TRY,   8'hff,  1'b0, 8'd0, STAT_OK},
        '{CMD_TRY,   8'd0,   1'b1, 8'd0, STAT_NONE_FREED},
        '{CMD_ALLOC, 8'haa,  1'b0, 8'd0, STAT_OK},
        '{CMD_FREE,  8'haa,  1'b1, 8'd0, STAT_NOT_ALLOCATED},
        '{CMD_FREE,  8'd3,   1'b0, 8'd0, STAT_OK},
        '{CMD_NOP,   8'h55,  1'b1, 8'd0, STAT_OK},
        '{CMD_ALLOC, 8'd0,   1'b0, 8'd0, STAT_OK},
        '{CMD_FREE,  8'd0,   1'b0, 8'd0, STAT_OK},
        '{CMD_FREE,  8'd128, 1'b1, 8'd0, STAT_NOT_ALLOCATED}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fhpa_req_if req_ch ();
    fhpa_rsp_if rsp_ch ();

    fifo_handle_pool_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror of the allocator state, advanced on every accepted request word.
    logic [COUNT_W-1:0] fresh_next;
    handle_t            freed_list [$];
    bit                 in_use [256];

    reply_t owed_replies [$];   // replies still to come, oldest first

    // Word on offer: typed-in reply, if any. Written at the falling edge.
    bit      offer_typed;
    handle_t offer_handle;
    status_t offer_status;

    bit calm;
    int words_sent;
    int replies_seen;
    int mismatches;
    int stall_cycles;
    int status_tally [4];
    int deepest_freed;

    // One allocator step: updates the mirror, returns the reply it owes.
    function automatic reply_t pool_outcome(input cmd_t cmd, input handle_t h);
        reply_t r;
        r.handle = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_ALLOC, CMD_TRY:
            begin
                if (freed_list.size() != 0)
                begin
                    r.handle = freed_list.pop_front();
                    in_use[r.handle] = 1'b1;
                end
                else if (cmd == CMD_TRY)
                    r.status = STAT_NONE_FREED;
                else if (fresh_next < CAP)
                begin
                    r.handle = fresh_next[HANDLE_W-1:0];
                    fresh_next = fresh_next + 1'b1;
                    in_use[r.handle] = 1'b1;
                end
                else
                    r.status = STAT_EXHAUSTED;
            end
            CMD_FREE:
            begin
                if (int'(h) < CAP && in_use[h])
                begin
                    in_use[h] = 1'b0;
                    // guarded push; cannot actually overflow
                    if (freed_list.size() < QUEUE_DEPTH)
                        freed_list.push_back(h);
                end
                else
                    r.status = STAT_NOT_ALLOCATED;
            end
            default: ;  // unused code: no-op
        endcase
        return r;
    endfunction

    // Random request word; outside the fill mix, releases mostly target held handles.
    function automatic void pick_word(input mix_t mix, output cmd_t cmd, output handle_t h);
        int r;
        int start;
        int p_alloc;
        int p_try;
        int p_owned;
        int p_any;
        r     = $urandom_range(0, 99);
        start = $urandom_range(0, 255);
        h     = handle_t'($urandom_range(0, 255));
        case (mix)
            MIX_FILL:  begin p_alloc = 96; p_try = 1;  p_owned = 1;  p_any = 1;  end
            MIX_DRAIN: begin p_alloc = 3;  p_try = 5;  p_owned = 85; p_any = 5;  end
            default:   begin p_alloc = 35; p_try = 10; p_owned = 35; p_any = 13; end
        endcase
        if (r < p_alloc)
            cmd = CMD_ALLOC;
        else if (r < p_alloc + p_try)
            cmd = CMD_TRY;
        else if (r < p_alloc + p_try + p_owned)
        begin
            cmd = CMD_FREE;
            // first held handle from a random start; random handle if none held
            for (int k = 0; k < 256; k++)
            begin
                if (in_use[(start + k) % 256])
                begin
                    h = handle_t'((start + k) % 256);
                    break;
                end
            end
        end
        else if (r < p_alloc + p_try + p_owned + p_any)
            cmd = CMD_FREE;
        else
            cmd = CMD_NOP;
    endfunction

    // Present one word from a falling edge, maybe after an idle burst, and
    // return at the rising edge that accepts it.
    task automatic offer(input cmd_t cmd, input handle_t h, input bit typed,
                         input handle_t want_h, input status_t want_s);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        offer_typed  = typed;
        offer_handle = want_h;
        offer_status = want_s;
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.handle_in <= h;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Sender goes quiet until every owed reply is back.
    task automatic hold_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(negedge clk);
    endtask

    // Checker and watchdog. Replies are matched before the new request is
    // predicted so a reply with nothing owed is never masked.
    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        bit     moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                replies_seen++;
                if (owed_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: reply with nothing owed: handle %0d status %0d",
                                 $realtime, rsp_ch.handle_out, rsp_ch.status);
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (rsp_ch.handle_out !== want.handle || rsp_ch.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: reply %0d: handle exp %0d got %0d, status exp %s got %0d",
                                     $realtime, replies_seen, want.handle, rsp_ch.handle_out,
                                     want.status.name(), rsp_ch.status);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                got = pool_outcome(cmd_t'(req_ch.command), req_ch.handle_in);
                status_tally[got.status]++;
                if (freed_list.size() > deepest_freed)
                    deepest_freed = freed_list.size();
                if (offer_typed)
                begin
                    want.handle = offer_handle;
                    want.status = offer_status;
                    owed_replies.push_back(want);
                end
                else
                    owed_replies.push_back(got);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: %0d cycles with no word moving, %0d replies owed",
                         STALL_LIMIT, owed_replies.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Reply side: random stall bursts, one long hold-off so the block backs
    // up and stalls its request side, no stalls once the run turns calm.
    initial
    begin : reply_taker
        int idle_left;
        int hold_left;
        bit held_once;
        idle_left = 0;
        hold_left = 0;
        held_once = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!held_once && replies_seen >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                idle_left = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Request side: reset, directed table, then the three random mixes.
    initial
    begin : word_source
        cmd_t    cmd;
        handle_t h;
        fresh_next    = '0;
        calm          = 1'b0;
        words_sent    = 0;
        replies_seen  = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        deepest_freed = 0;
        foreach (in_use[i])
            in_use[i] = 1'b0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_NOP;
        req_ch.handle_in <= '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
        begin
            offer(DIRECTED[i].command, DIRECTED[i].handle, DIRECTED[i].typed,
                  DIRECTED[i].want_handle, DIRECTED[i].want_status);
            words_sent++;
        end
        hold_until_drained();

        for (int m = 0; m < 3; m++)
        begin
            for (int i = 0; i < MIX_LEN[m]; i++)
            begin
                calm = (words_sent - N_DIRECTED >= CALM_FROM);
                pick_word(mix_t'(m), cmd, h);
                offer(cmd, h, 1'b0, '0, STAT_OK);
                words_sent++;
            end
            // pause between mixes until the block has answered everything
            hold_until_drained();
        end

        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d words: %0d ok, %0d try misses, %0d bad releases, %0d exhausted",
                 words_sent, status_tally[STAT_OK], status_tally[STAT_NONE_FREED],
                 status_tally[STAT_NOT_ALLOCATED], status_tally[STAT_EXHAUSTED]);
        $display("Fresh handles issued %0d, deepest freed list %0d, mismatches %0d",
                 fresh_next, deepest_freed, mismatches);
        if (owed_replies.size() != 0)
            $display("%0d replies never arrived", owed_replies.size());
        if (mismatches == 0 && owed_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
